// ----- hw/rtl/multi_channel_periodic_timer_assert.svh -----
// assertion macros used by the checker file
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MCPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// delayed implication, sampled on clk, off while rst_n is low
`define MCPT_ASSERT_TWO(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mcpt_pkg.sv -----
`default_nettype none
package mcpt_pkg;

  localparam int DEF_CHANNELS   = 16;
  localparam int DEF_COUNT_BITS = 32;
  localparam int MAX_RESULTS    = 16;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_SET_RATE = 3'd1,
    ACT_START    = 3'd2,
    ACT_START_AT = 3'd3,
    ACT_STOP     = 3'd4,
    ACT_RESET    = 3'd5,
    ACT_QUERY    = 3'd6
  } action_t;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  channel;
    logic [31:0] value;
  } mcpt_in_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [31:0] tick_stamp;
    logic [31:0] rate_now;
    logic [31:0] count_now;
    logic        running;
    logic        last;
  } mcpt_out_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic flush;
  } mcpt_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mcpt_ram.sv -----
`default_nettype none
module mcpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/mcpt_ctrl.sv -----
`default_nettype none
module mcpt_ctrl #(
  parameter int CHANNELS = mcpt_pkg::DEF_CHANNELS,
  parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          in_action,
  input  logic [3:0]          in_channel,
  output logic                busy,
  output mcpt_pkg::mcpt_cmd_t cmd,
  output logic [CH_W-1:0]     rd_addr
);
  import mcpt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CMD   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] idx_r, idx_nxt;

  // sequencing of commands and channel scans
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    rd_addr   = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        idx_nxt = '0;
        if (in_action != ACT_TICK) begin
          rd_addr = CH_W'(in_channel);
        end
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_TICK) ? ST_SCAN : ST_CMD;
        end
      end
      ST_CMD: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        rd_addr  = CH_W'(idx_r + 1'b1);
        idx_nxt  = CH_W'(idx_r + 1'b1);
        if (idx_r == CH_W'(CHANNELS - 1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mcpt_dp.sv -----
`default_nettype none
module mcpt_dp #(
  parameter int CHANNELS   = mcpt_pkg::DEF_CHANNELS,
  parameter int COUNT_BITS = mcpt_pkg::DEF_COUNT_BITS,
  parameter int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mcpt_pkg::mcpt_cmd_t cmd,
  input  logic [CH_W-1:0]     rd_addr,
  input  mcpt_pkg::mcpt_in_t  in_data,
  output logic                out_valid,
  output mcpt_pkg::mcpt_out_t out_data
);
  import mcpt_pkg::*;

  localparam int RC_W = $clog2(MAX_RESULTS + 1);

  mcpt_in_t              item_r;
  logic [31:0]           ticks_r;
  logic [CHANNELS-1:0]   run_r;
  logic [CHANNELS-1:0]   vld_r;
  logic [CH_W-1:0]       addr_q_r;
  logic                  vq_r;
  mcpt_out_t             held_r;
  logic                  held_vld_r;
  logic [RC_W-1:0]       rep_cnt_r;
  mcpt_out_t             out_r;
  logic                  out_vld_r;

  logic [COUNT_BITS-1:0] rate_rd, cnt_rd;
  logic [COUNT_BITS-1:0] rate_q, cnt_q, dec_c, val_c;
  logic [COUNT_BITS-1:0] rate_w, cnt_w;
  logic                  run_w, wr_en, oor, active, expire;
  mcpt_out_t             status_c, expiry_c;

  // rate and count stores, shared read address
  mcpt_ram #(.WIDTH(COUNT_BITS), .DEPTH(CHANNELS), .AW(CH_W)) u_rate_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_q_r),
    .wdata (rate_w),
    .raddr (rd_addr),
    .rdata (rate_rd)
  );

  mcpt_ram #(.WIDTH(COUNT_BITS), .DEPTH(CHANNELS), .AW(CH_W)) u_cnt_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_q_r),
    .wdata (cnt_w),
    .raddr (rd_addr),
    .rdata (cnt_rd)
  );

  // never-written entries read as zero
  assign rate_q = vq_r ? rate_rd : '0;
  assign cnt_q  = vq_r ? cnt_rd : '0;
  assign val_c  = item_r.value[COUNT_BITS-1:0];
  assign dec_c  = cnt_q - 1'b1;
  assign oor    = 32'(item_r.channel) >= 32'(CHANNELS);
  assign active = run_r[addr_q_r] && (rate_q != '0);
  assign expire = active && (dec_c == '0);

  // next channel state for a command or a scan step
  always_comb begin
    rate_w = rate_q;
    cnt_w  = cnt_q;
    run_w  = run_r[addr_q_r];
    wr_en  = 1'b0;
    if (cmd.exec) begin
      wr_en = !oor;
      unique case (item_r.action)
        ACT_SET_RATE: begin
          rate_w = val_c;
          cnt_w  = val_c;
        end
        ACT_START: begin
          run_w = 1'b1;
          cnt_w = rate_q;
        end
        ACT_START_AT: begin
          run_w = 1'b1;
          cnt_w = val_c;
        end
        ACT_STOP: begin
          run_w = 1'b0;
        end
        ACT_RESET: begin
          cnt_w = rate_q;
        end
        default: begin
        end
      endcase
    end else if (cmd.step) begin
      wr_en = active;
      cnt_w = expire ? rate_q : dec_c;
    end
  end

  // result words
  always_comb begin
    status_c.kind       = KIND_STATUS;
    status_c.slot       = item_r.channel;
    status_c.tick_stamp = ticks_r;
    status_c.rate_now   = oor ? '0 : 32'(rate_w);
    status_c.count_now  = oor ? '0 : 32'(cnt_w);
    status_c.running    = oor ? 1'b0 : run_w;
    status_c.last       = 1'b1;
    expiry_c.kind       = KIND_EXPIRY;
    expiry_c.slot       = 4'(addr_q_r);
    expiry_c.tick_stamp = ticks_r;
    expiry_c.rate_now   = 32'(rate_q);
    expiry_c.count_now  = 32'(rate_q);
    expiry_c.running    = 1'b1;
    expiry_c.last       = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= '0;
      run_r      <= '0;
      vld_r      <= '0;
      vq_r       <= 1'b0;
      held_vld_r <= 1'b0;
      rep_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      vq_r      <= vld_r[rd_addr];
      out_vld_r <= 1'b0;
      if (cmd.load) begin
        rep_cnt_r  <= '0;
        held_vld_r <= 1'b0;
        if (in_data.action == ACT_TICK) begin
          ticks_r <= ticks_r + 1'b1;
        end
      end
      if (wr_en) begin
        vld_r[addr_q_r] <= 1'b1;
      end
      if (cmd.exec) begin
        out_vld_r <= 1'b1;
        if (!oor) begin
          run_r[addr_q_r] <= run_w;
        end
      end
      // hold each expiry until the next one shows it was not the last
      if (cmd.step && expire && (rep_cnt_r < RC_W'(MAX_RESULTS))) begin
        held_vld_r <= 1'b1;
        rep_cnt_r  <= rep_cnt_r + 1'b1;
        if (held_vld_r) begin
          out_vld_r <= 1'b1;
        end
      end
      if (cmd.flush && held_vld_r) begin
        out_vld_r  <= 1'b1;
        held_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    addr_q_r <= rd_addr;
    if (cmd.exec) begin
      out_r <= status_c;
    end
    if (cmd.step && expire && (rep_cnt_r < RC_W'(MAX_RESULTS))) begin
      held_r <= expiry_c;
      out_r  <= held_r;
    end
    if (cmd.flush) begin
      out_r      <= held_r;
      out_r.last <= 1'b1;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/multi_channel_periodic_timer.sv -----
`default_nettype none
// Bank of CHANNELS periodic down-counting timers in fixed slots.
// Input: in_data (action, channel, value) is taken on a clock edge where
// start is high and busy is low. Action tick advances the global tick
// count and visits every channel; other actions address one channel.
// Output: each result is on out_data for one cycle with out_valid high.
// The receiver cannot stall, so results are never held back.
// A command moves through state CMD with busy high, and its single status
// result (last set) is registered there and appears once busy is low again.
// A tick keeps busy high while it steps through every channel in a
// pipelined read-modify-write over the rate and count memories, one read
// port each, and then while it releases the final held expiry.
// Expiries come out in ascending slot order, at most 16 per tick, the last
// one released by the flush state after the scan; a tick without
// expiries gives no result.
// Reset (rst_n low, synchronous) stops all channels, zeroes the tick
// count and marks all rate and count entries as zero.
module multi_channel_periodic_timer #(
  parameter int CHANNELS   = mcpt_pkg::DEF_CHANNELS,
  parameter int COUNT_BITS = mcpt_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mcpt_pkg::mcpt_in_t  in_data,
  output logic                out_valid,
  output mcpt_pkg::mcpt_out_t out_data
);
  import mcpt_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mcpt_cmd_t       cmd;
  logic [CH_W-1:0] rd_addr;

  // sequencer
  mcpt_ctrl #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_action  (in_data.action),
    .in_channel (in_data.channel),
    .busy       (busy),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  // channel state and result registers
  mcpt_dp #(.CHANNELS(CHANNELS), .COUNT_BITS(COUNT_BITS), .CH_W(CH_W)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/mcpt_checker.sv -----
`default_nettype none
`include "multi_channel_periodic_timer_assert.svh"
module mcpt_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire mcpt_pkg::mcpt_in_t  in_data,
  input wire logic                out_valid,
  input wire mcpt_pkg::mcpt_out_t out_data
);
  import mcpt_pkg::*;

  logic cmd_acc;
  logic status_beat;
  logic status_ok;
  logic expiry_beat;
  logic expiry_ok;

  // handshake and beat qualifiers
  assign cmd_acc     = start && !busy && (in_data.action != ACT_TICK);
  assign status_beat = out_valid && (out_data.kind == KIND_STATUS);
  assign status_ok   = status_beat && out_data.last;
  assign expiry_beat = out_valid && (out_data.kind == KIND_EXPIRY);
  assign expiry_ok   = out_data.running && (out_data.count_now == out_data.rate_now) &&
                       (out_data.rate_now != '0);

  // a command accept is followed by a status beat with last set
  `MCPT_ASSERT_TWO(a_cmd_status, cmd_acc, status_ok, "command status missing")

  // a status beat always closes its item
  `MCPT_ASSERT_NOW(a_status_last, status_beat, out_data.last, "status without last")

  // an expiry shows a running channel reloaded from a nonzero rate
  `MCPT_ASSERT_NOW(a_expiry_reload, expiry_beat, expiry_ok, "bad expiry reload")

  // status beats appear only once the block is idle again
  `MCPT_ASSERT_NOW(a_status_idle, status_beat, !busy, "status while busy")

endmodule

bind multi_channel_periodic_timer mcpt_checker u_mcpt_checker (.*);
`default_nettype wire
